@@ hw/rtl/cvcl_pkg.sv @@
// Shared types and constants for the cascaded voltage/current control loop.
// Depends on nothing; every RTL file of the block imports it.
package cvcl_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int GAIN_W       = 16;
  localparam int REF_W        = 15;
  localparam int DUTY_W       = 16;
  localparam int INTEG_W      = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CNT_W        = $clog2(GAIN_W);

  localparam int ERR_W  = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 2;
  localparam int PROD_W = ERR_W + GAIN_W + 1;

  localparam int OUT_SHIFT = 12;
  localparam int OUT_RND   = 2048;
  localparam int IN_SHIFT  = 4;
  localparam int IN_RND    = 8;
  localparam int RED_W     = PROD_W - OUT_SHIFT;
  localparam int DEL_W     = PROD_W - IN_SHIFT;

  localparam int INTEG_LIMIT = 1280;

  localparam logic [REF_W-1:0]  VSET_RESET  = REF_W'(3072);
  localparam logic [GAIN_W-1:0] KPV_RESET   = GAIN_W'(2048);
  localparam logic [GAIN_W-1:0] KIV_RESET   = GAIN_W'(410);
  localparam logic [GAIN_W-1:0] KPI_RESET   = GAIN_W'(1229);
  localparam logic [REF_W-1:0]  IFLOOR_RESET = REF_W'(26);
  localparam logic [REF_W-1:0]  ICEIL_RESET  = REF_W'(1280);
  localparam logic [DUTY_W-1:0] DFLOOR_RESET = DUTY_W'(3277);
  localparam logic [DUTY_W-1:0] DCEIL_RESET  = DUTY_W'(62259);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VSET   = 3'd0,
    REG_KPV    = 3'd1,
    REG_KIV    = 3'd2,
    REG_KPI    = 3'd3,
    REG_IFLOOR = 3'd4,
    REG_ICEIL  = 3'd5,
    REG_DFLOOR = 3'd6,
    REG_DCEIL  = 3'd7
  } cfg_reg_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_V = 7'b0000010,
    ST_INTEG = 7'b0000100,
    ST_IREF  = 7'b0001000,
    ST_IERR  = 7'b0010000,
    ST_MUL_I = 7'b0100000,
    ST_DUTY  = 7'b1000000
  } state_t;

endpackage

@@ hw/rtl/cascaded_voltage_current_loop.sv @@
// Cascaded PI voltage / P current controller for a DC-DC converter.
// Depends on cvcl_pkg for widths, register codes and the state type.
//
// Usage: each input item (voltage_measured, current_measured, signed Q7.8) is
// taken on in_valid/in_ready and yields one result item (current_reference,
// duty_out) on out_valid/out_ready. Gains, setpoint and limits must be written
// through cfg_we/cfg_index/cfg_data while the block is idle; the block itself does not enforce this.
// The products are formed by bit-serial shift-add logic that consumes one
// gain bit per cycle; the voltage loop runs its two products side by side,
// and the current loop then reuses the first of the two for its product.
// An item is accepted only while idle, so each item is finished before the
// next is taken; a new item can be accepted in the cycle after the result is registered.
// The result sits in an output register; while the receiver stalls, the next
// item is accepted and processed, and it waits in its last step until the
// output register is free.
// Reset restores the register defaults, clears the integral and the stored
// duty, and empties the output register.
module cascaded_voltage_current_loop
  import cvcl_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] voltage_measured,
  input  logic signed [SAMPLE_WIDTH-1:0] current_measured,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [REF_W-1:0]               current_reference,
  output logic [DUTY_W-1:0]              duty_out
);

  logic [REF_W-1:0]  vset;
  logic [GAIN_W-1:0] kpv;
  logic [GAIN_W-1:0] kiv;
  logic [GAIN_W-1:0] kpi;
  logic [REF_W-1:0]  ifloor;
  logic [REF_W-1:0]  iceil;
  logic [DUTY_W-1:0] dfloor;
  logic [DUTY_W-1:0] dceil;

  state_t state;
  logic [CNT_W-1:0] cnt;

  logic signed [ERR_W-1:0]        err;
  logic signed [SAMPLE_WIDTH-1:0] imeas;
  logic [GAIN_W-1:0]              gain_a;
  logic [GAIN_W-1:0]              gain_b;
  logic signed [PROD_W-1:0]       acc_a;
  logic signed [PROD_W-1:0]       acc_b;
  logic signed [INTEG_W-1:0]      integ;
  logic [DUTY_W-1:0]              duty_acc;
  logic [REF_W-1:0]               iref;

  logic signed [PROD_W-1:0] err_ext;
  logic signed [PROD_W-1:0] acc_a_next;
  logic signed [PROD_W-1:0] acc_b_next;
  logic signed [PROD_W-1:0] rnd_a;
  logic signed [PROD_W-1:0] rnd_b;
  logic signed [PROD_W-1:0] rnd_i;
  logic signed [RED_W-1:0]  prop;
  logic signed [RED_W-1:0]  inc;
  logic signed [RED_W:0]    isum;
  logic signed [RED_W:0]    rsum;
  logic signed [DEL_W-1:0]  delta;
  logic signed [DEL_W:0]    dsum;
  logic signed [INTEG_W-1:0] integ_next;
  logic [REF_W-1:0]         iref_next;
  logic [DUTY_W-1:0]        duty_next;
  logic                     out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // One step of the MSB-first shift-add multiplier.
  assign err_ext    = PROD_W'(err);
  assign acc_a_next = (acc_a <<< 1) + (gain_a[GAIN_W-1] ? err_ext : '0);
  assign acc_b_next = (acc_b <<< 1) + (gain_b[GAIN_W-1] ? err_ext : '0);

  assign rnd_a = acc_a + PROD_W'(OUT_RND);
  assign rnd_b = acc_b + PROD_W'(OUT_RND);
  assign rnd_i = acc_a + PROD_W'(IN_RND);
  assign prop  = rnd_a[PROD_W-1:OUT_SHIFT];
  assign inc   = rnd_b[PROD_W-1:OUT_SHIFT];
  assign delta = rnd_i[PROD_W-1:IN_SHIFT];

  assign isum = (RED_W+1)'(inc) + (RED_W+1)'(integ);
  assign rsum = (RED_W+1)'(prop) + (RED_W+1)'(integ);
  assign dsum = (DEL_W+1)'(delta) + signed'((DEL_W+1)'(duty_acc));

  always_comb begin
    if (isum > (RED_W+1)'(INTEG_LIMIT)) begin
      integ_next = INTEG_W'(INTEG_LIMIT);
    end else if (isum < -(RED_W+1)'(INTEG_LIMIT)) begin
      integ_next = -INTEG_W'(INTEG_LIMIT);
    end else begin
      integ_next = isum[INTEG_W-1:0];
    end
  end

  always_comb begin
    if (rsum < signed'((RED_W+1)'(ifloor))) begin
      iref_next = ifloor;
    end else if (rsum > signed'((RED_W+1)'(iceil))) begin
      iref_next = iceil;
    end else begin
      iref_next = rsum[REF_W-1:0];
    end
  end

  always_comb begin
    if (dsum < signed'((DEL_W+1)'(dfloor))) begin
      duty_next = dfloor;
    end else if (dsum > signed'((DEL_W+1)'(dceil))) begin
      duty_next = dceil;
    end else begin
      duty_next = dsum[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vset   <= VSET_RESET;
      kpv    <= KPV_RESET;
      kiv    <= KIV_RESET;
      kpi    <= KPI_RESET;
      ifloor <= IFLOOR_RESET;
      iceil  <= ICEIL_RESET;
      dfloor <= DFLOOR_RESET;
      dceil  <= DCEIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VSET:   vset   <= cfg_data[REF_W-1:0];
        REG_KPV:    kpv    <= cfg_data[GAIN_W-1:0];
        REG_KIV:    kiv    <= cfg_data[GAIN_W-1:0];
        REG_KPI:    kpi    <= cfg_data[GAIN_W-1:0];
        REG_IFLOOR: ifloor <= cfg_data[REF_W-1:0];
        REG_ICEIL:  iceil  <= cfg_data[REF_W-1:0];
        REG_DFLOOR: dfloor <= cfg_data[DUTY_W-1:0];
        REG_DCEIL:  dceil  <= cfg_data[DUTY_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      integ     <= '0;
      duty_acc  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DUTY)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            err    <= ERR_W'(signed'({1'b0, vset})) - ERR_W'(voltage_measured);
            imeas  <= current_measured;
            acc_a  <= '0;
            acc_b  <= '0;
            gain_a <= kpv;
            gain_b <= kiv;
            cnt    <= '0;
            state  <= ST_MUL_V;
          end
        end
        ST_MUL_V: begin
          acc_a  <= acc_a_next;
          acc_b  <= acc_b_next;
          gain_a <= gain_a << 1;
          gain_b <= gain_b << 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(GAIN_W-1)) begin
            state <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integ <= integ_next;
          state <= ST_IREF;
        end
        ST_IREF: begin
          iref  <= iref_next;
          state <= ST_IERR;
        end
        ST_IERR: begin
          err    <= ERR_W'(signed'({1'b0, iref})) - ERR_W'(imeas);
          acc_a  <= '0;
          gain_a <= kpi;
          cnt    <= '0;
          state  <= ST_MUL_I;
        end
        ST_MUL_I: begin
          acc_a  <= acc_a_next;
          gain_a <= gain_a << 1;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(GAIN_W-1)) begin
            state <= ST_DUTY;
          end
        end
        ST_DUTY: begin
          if (out_free) begin
            duty_acc          <= duty_next;
            current_reference <= iref;
            duty_out          <= duty_next;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/cvcl_checker.sv @@
// Port-level checks for the cascaded voltage/current control loop.
// Depends on cvcl_pkg; bound to the top level at the end of this file.
module cvcl_port_checker
  import cvcl_pkg::*;
(
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [CFG_IDX_W-1:0]           cfg_index,
  input logic [CFG_W-1:0]               cfg_data,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic signed [SAMPLE_WIDTH-1:0] voltage_measured,
  input logic signed [SAMPLE_WIDTH-1:0] current_measured,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [REF_W-1:0]               current_reference,
  input logic [DUTY_W-1:0]              duty_out
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result item present right after reset");

  // Only one item is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // A new result is registered in the same cycle the block turns idle.
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result registered without returning to idle");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_reference)
      && $stable(duty_out))
    else $error("stalled result item changed");

endmodule

bind cascaded_voltage_current_loop cvcl_port_checker u_cvcl_checker (.*);

@@ test/cvcl_checker.sv @@
// Result checker for the cascaded voltage/current control loop testbench.
// Watches the configuration port and both item channels, predicts each result and compares.
// Depends on cvcl_pkg for widths, register codes and reset values.
module cvcl_checker
  import cvcl_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] voltage_measured,
  input  logic signed [SAMPLE_WIDTH-1:0] current_measured,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [REF_W-1:0]               current_reference,
  input  logic [DUTY_W-1:0]              duty_out,
  output int                             mismatches,
  output int                             awaiting
);

  typedef struct packed {
    logic [REF_W-1:0]  iref;
    logic [DUTY_W-1:0] duty;
  } loop_result_t;

  loop_result_t loop_results_q[$];
  loop_result_t oldest;

  longint vset, kpv, kiv, kpi, iref_floor, iref_ceil, duty_lo, duty_hi;
  longint integ_acc, duty_acc;

  int mismatch_count = 0;
  int queued = 0;

  assign mismatches = mismatch_count;
  assign awaiting   = queued;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic longint bound(input longint x, input longint lo, input longint hi);
    if (x < lo) begin
      return lo;
    end
    if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  task automatic predict_control_step(input logic signed [SAMPLE_WIDTH-1:0] vm,
                                      input logic signed [SAMPLE_WIDTH-1:0] cm);
    longint verr, prop, incr, iref, ierr, delta;
    loop_result_t r;
    verr      = vset - longint'(vm);
    prop      = (kpv * verr + 2048) >>> 12;
    incr      = (kiv * verr + 2048) >>> 12;
    integ_acc = bound(integ_acc + incr, -INTEG_LIMIT, INTEG_LIMIT);
    iref      = bound(prop + integ_acc, iref_floor, iref_ceil);
    ierr      = iref - longint'(cm);
    delta     = (kpi * ierr + 8) >>> 4;
    duty_acc  = bound(duty_acc + delta, duty_lo, duty_hi);
    r.iref    = iref[REF_W-1:0];
    r.duty    = duty_acc[DUTY_W-1:0];
    loop_results_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      vset       = longint'(VSET_RESET);
      kpv        = longint'(KPV_RESET);
      kiv        = longint'(KIV_RESET);
      kpi        = longint'(KPI_RESET);
      iref_floor = longint'(IFLOOR_RESET);
      iref_ceil  = longint'(ICEIL_RESET);
      duty_lo    = longint'(DFLOOR_RESET);
      duty_hi    = longint'(DCEIL_RESET);
      integ_acc  = 0;
      duty_acc   = 0;
      loop_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VSET:   vset       = longint'(cfg_data[REF_W-1:0]);
          REG_KPV:    kpv        = longint'(cfg_data[GAIN_W-1:0]);
          REG_KIV:    kiv        = longint'(cfg_data[GAIN_W-1:0]);
          REG_KPI:    kpi        = longint'(cfg_data[GAIN_W-1:0]);
          REG_IFLOOR: iref_floor = longint'(cfg_data[REF_W-1:0]);
          REG_ICEIL:  iref_ceil  = longint'(cfg_data[REF_W-1:0]);
          REG_DFLOOR: duty_lo    = longint'(cfg_data[DUTY_W-1:0]);
          REG_DCEIL:  duty_hi    = longint'(cfg_data[DUTY_W-1:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (loop_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result item, current_reference=%0d duty_out=%0d",
                                    current_reference, duty_out));
        end else begin
          oldest = loop_results_q.pop_front();
          if (current_reference !== oldest.iref) begin
            report_mismatch($sformatf("current_reference is %0d, expected %0d",
                                      current_reference, oldest.iref));
          end
          if (duty_out !== oldest.duty) begin
            report_mismatch($sformatf("duty_out is %0d, expected %0d", duty_out, oldest.duty));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_control_step(voltage_measured, current_measured);
      end
    end
    queued = loop_results_q.size();
  end

endmodule

@@ test/tb_cascaded_voltage_current_loop.sv @@
// Top of the testbench for the cascaded voltage/current control loop.
// Drives directed and random items and register settings; cvcl_checker predicts and compares.
// Depends on cvcl_pkg, cvcl_checker and the block itself.
module tb_cascaded_voltage_current_loop;
  import cvcl_pkg::*;

  localparam int NUM_REGS     = 8;
  localparam int ITEMS_PER_PH = 200;
  localparam int NUM_PHASES   = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  cfg_reg_t                       cfg_index = REG_VSET;
  logic [CFG_W-1:0]               cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [SAMPLE_WIDTH-1:0] voltage_measured = '0;
  logic signed [SAMPLE_WIDTH-1:0] current_measured = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [REF_W-1:0]               current_reference;
  logic [DUTY_W-1:0]              duty_out;

  int mismatches;
  int awaiting;

  logic [CFG_W-1:0] setting [NUM_REGS];
  int  vset_now      = 3072;
  bit  in_gaps_on    = 1'b1;
  bit  out_stalls_on = 1'b1;
  int  stall_left    = 0;
  int  cycles        = 0;

  cascaded_voltage_current_loop dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .voltage_measured(voltage_measured), .current_measured(current_measured),
    .out_valid(out_valid), .out_ready(out_ready),
    .current_reference(current_reference), .duty_out(duty_out)
  );

  cvcl_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .voltage_measured(voltage_measured), .current_measured(current_measured),
    .out_valid(out_valid), .out_ready(out_ready),
    .current_reference(current_reference), .duty_out(duty_out),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 80);
    end
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (out_stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  function automatic logic [SAMPLE_WIDTH-1:0] pick_voltage();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return SAMPLE_WIDTH'(vset_now + $urandom_range(0, 1023) - 512);
      6, 7:             return SAMPLE_WIDTH'($urandom);
      8:                return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default:          return '0;
    endcase
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] pick_current();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return SAMPLE_WIDTH'($urandom_range(0, 2047) - 512);
      7, 8:                return SAMPLE_WIDTH'($urandom);
      default:             return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  task automatic drive_sample(input logic [SAMPLE_WIDTH-1:0] v, input logic [SAMPLE_WIDTH-1:0] c);
    int gap;
    gap = 0;
    if (in_gaps_on && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    voltage_measured = v;
    current_measured = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic apply_settings();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    = 1'b1;
      cfg_index = cfg_reg_t'(i);
      cfg_data  = setting[i];
      @(negedge clk);
    end
    cfg_we   = 1'b0;
    vset_now = setting[REG_VSET] & 16'h7FFF;
  endtask

  initial begin
    int lo, hi, tmp;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    drive_sample(16'h8000, 16'h8000);
    drive_sample(16'h7FFF, 16'h7FFF);
    drive_sample(16'h8000, 16'h7FFF);
    drive_sample(16'h7FFF, 16'h8000);
    drive_sample(16'd3072, 16'h0000);
    repeat (6) drive_sample(16'h0000, 16'h0000);
    repeat (5) drive_sample(16'h7FFF, 16'h0000);
    settle();

    // Gains at full scale, a setpoint with its dropped top bit set, and floors above ceilings.
    setting[REG_VSET]   = 16'hFFFF;
    setting[REG_KPV]    = 16'hFFFF;
    setting[REG_KIV]    = 16'hFFFF;
    setting[REG_KPI]    = 16'hFFFF;
    setting[REG_IFLOOR] = 16'd2000;
    setting[REG_ICEIL]  = 16'd1000;
    setting[REG_DFLOOR] = 16'd50000;
    setting[REG_DCEIL]  = 16'd10000;
    apply_settings();
    drive_sample(16'h8000, 16'h0000);
    drive_sample(16'h7FFF, 16'h0000);
    drive_sample(16'h0000, 16'h7FFF);
    drive_sample(16'h0000, 16'h8000);
    settle();

    setting[REG_VSET]   = 16'h0000;
    setting[REG_KPV]    = 16'h0000;
    setting[REG_KIV]    = 16'h0000;
    setting[REG_KPI]    = 16'h0000;
    setting[REG_IFLOOR] = 16'h0000;
    setting[REG_ICEIL]  = 16'h7FFF;
    setting[REG_DFLOOR] = 16'h0000;
    setting[REG_DCEIL]  = 16'hFFFF;
    apply_settings();
    drive_sample(16'h0000, 16'h0000);
    drive_sample(16'h7FFF, 16'h7FFF);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          setting[REG_VSET]   = CFG_W'(VSET_RESET);
          setting[REG_KPV]    = CFG_W'(KPV_RESET);
          setting[REG_KIV]    = CFG_W'(KIV_RESET);
          setting[REG_KPI]    = CFG_W'(KPI_RESET);
          setting[REG_IFLOOR] = CFG_W'(IFLOOR_RESET);
          setting[REG_ICEIL]  = CFG_W'(ICEIL_RESET);
          setting[REG_DFLOOR] = CFG_W'(DFLOOR_RESET);
          setting[REG_DCEIL]  = CFG_W'(DCEIL_RESET);
        end
        1: begin
          for (int i = 0; i < NUM_REGS; i++) setting[i] = '1;
        end
        2: begin
          for (int i = 0; i < NUM_REGS; i++) setting[i] = '0;
        end
        default: begin
          setting[REG_VSET] = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom)
                                                          : CFG_W'($urandom_range(0, 8191));
          setting[REG_KPV] = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(0, 8191));
          setting[REG_KIV] = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(0, 8191));
          setting[REG_KPI] = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                         : CFG_W'($urandom_range(0, 8191));
          lo = $urandom_range(0, 512);
          hi = $urandom_range(512, 4096);
          if ($urandom_range(0, 4) == 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          setting[REG_IFLOOR] = CFG_W'(lo);
          setting[REG_ICEIL]  = CFG_W'(hi);
          lo = $urandom_range(0, 16383);
          hi = $urandom_range(32768, 65535);
          if ($urandom_range(0, 4) == 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          setting[REG_DFLOOR] = CFG_W'(lo);
          setting[REG_DCEIL]  = CFG_W'(hi);
        end
      endcase
      apply_settings();
      in_gaps_on    = (ph != 3) && ($urandom_range(0, 3) != 0);
      out_stalls_on = (ph != 3) && ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_PH) drive_sample(pick_voltage(), pick_current());
      settle();
    end

    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
